[src/ccba_pkg.sv]
`timescale 1ns / 1ps

package ccba_pkg;

    // Field widths of the stream items and of the configuration port.
    localparam int CNT_W       = 7;
    localparam int ID_W        = 6;
    localparam int STAT_W      = 2;
    localparam int MASK_W      = 64;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_AW      = 1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_SEG_MASK   = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_CORE_COUNT = 1'd1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_GRANT   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_LOAD    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_FIT,
        ST_BEST,
        ST_EMIT,
        ST_FINAL,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_COUNT,
        CMD_FIT,
        CMD_BEST,
        CMD_EMIT,
        CMD_FINAL,
        CMD_RESP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              accept;
        logic [STAT_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic in_load;
        logic in_zero;
        logic in_last;
        logic scan_done;
        logic full;
        logic shot_gt1;
        logic best_any;
        logic out_free;
    } t_status;

endpackage

[src/ccba_ctrl.sv]
`timescale 1ns / 1ps

module ccba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ccba_pkg::t_status   i_status,
    output logic                o_in_ready,
    output ccba_pkg::t_cmd      o_cmd
);

    ccba_pkg::t_state r_state, n_state;
    logic [ccba_pkg::STAT_W-1:0] r_code, n_code;

    // State and response code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccba_pkg::ST_IDLE;
            r_code  <= ccba_pkg::STAT_GRANT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Next state logic.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        unique case (r_state)
            ccba_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_status.in_load) begin
                        n_state = ccba_pkg::ST_RESP;
                        n_code  = ccba_pkg::STAT_LOAD;
                    end else if (i_status.in_zero) begin
                        n_state = ccba_pkg::ST_RESP;
                        n_code  = ccba_pkg::STAT_ZERO;
                    end else if (i_status.in_last) begin
                        n_state = ccba_pkg::ST_COUNT;
                    end else begin
                        n_state = ccba_pkg::ST_FIT;
                    end
                end
            end
            ccba_pkg::ST_COUNT: begin
                if (i_status.scan_done) n_state = ccba_pkg::ST_FIT;
            end
            ccba_pkg::ST_FIT: begin
                if (i_status.scan_done) begin
                    priority if (i_status.full) begin
                        n_state = ccba_pkg::ST_EMIT;
                    end else if (i_status.shot_gt1) begin
                        n_state = ccba_pkg::ST_BEST;
                    end else begin
                        n_state = ccba_pkg::ST_RESP;
                        n_code  = ccba_pkg::STAT_NOSPACE;
                    end
                end
            end
            ccba_pkg::ST_BEST: begin
                if (i_status.scan_done) begin
                    if (i_status.best_any) begin
                        n_state = ccba_pkg::ST_EMIT;
                    end else begin
                        n_state = ccba_pkg::ST_RESP;
                        n_code  = ccba_pkg::STAT_NOSPACE;
                    end
                end
            end
            ccba_pkg::ST_EMIT: begin
                if (i_status.scan_done) n_state = ccba_pkg::ST_FINAL;
            end
            ccba_pkg::ST_FINAL,
            ccba_pkg::ST_RESP: begin
                if (i_status.out_free) n_state = ccba_pkg::ST_IDLE;
            end
            default: n_state = ccba_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd.op     = ccba_pkg::CMD_NONE;
        o_cmd.accept = 1'b0;
        o_cmd.code   = r_code;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ccba_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ccba_pkg::ST_COUNT: o_cmd.op = ccba_pkg::CMD_COUNT;
            ccba_pkg::ST_FIT:   o_cmd.op = ccba_pkg::CMD_FIT;
            ccba_pkg::ST_BEST:  o_cmd.op = ccba_pkg::CMD_BEST;
            ccba_pkg::ST_EMIT:  o_cmd.op = ccba_pkg::CMD_EMIT;
            ccba_pkg::ST_FINAL: o_cmd.op = ccba_pkg::CMD_FINAL;
            ccba_pkg::ST_RESP:  o_cmd.op = ccba_pkg::CMD_RESP;
            default:            o_cmd.op = ccba_pkg::CMD_NONE;
        endcase
    end

endmodule

[src/ccba_dpath.sv]
`timescale 1ns / 1ps

module ccba_dpath #(
    parameter int MAX_CORES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ccba_pkg::t_cmd                       i_cmd,
    output ccba_pkg::t_status                    o_status,
    // Input item fields.
    input  logic                                 i_op,
    input  logic [ccba_pkg::MASK_W-1:0]          i_free_mask,
    input  logic [ccba_pkg::CNT_W-1:0]           i_max_cores,
    input  logic [ccba_pkg::CNT_W-1:0]           i_cores_per_shot,
    input  logic                                 i_last_one,
    // Configuration writes.
    input  logic                                 i_cfg_we,
    input  logic [ccba_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [ccba_pkg::CFG_W-1:0]           i_cfg_data,
    // Result register.
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [ccba_pkg::ID_W-1:0]            o_core_id,
    output logic [ccba_pkg::STAT_W-1:0]          o_stat,
    output logic                                 o_last
);

    localparam int PW = $clog2(MAX_CORES + 1);
    localparam int IW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam logic [ccba_pkg::CNT_W-1:0] MAX_N = ccba_pkg::CNT_W'(MAX_CORES);

    logic [ccba_pkg::MASK_W-1:0] r_seg_mask;
    logic [ccba_pkg::CNT_W-1:0]  r_core_count;

    logic [MAX_CORES-1:0]        r_map, n_map;
    logic [MAX_CORES-1:0]        r_snap, n_snap;
    logic [MAX_CORES-1:0]        r_run, n_run;
    logic [MAX_CORES-1:0]        r_best_mask, n_best_mask;
    logic [PW-1:0]               r_pos, n_pos;
    logic [ccba_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [ccba_pkg::CNT_W-1:0]  r_fc, n_fc;
    logic [ccba_pkg::CNT_W-1:0]  r_budget, n_budget;
    logic [ccba_pkg::CNT_W-1:0]  r_shot, n_shot;
    logic [ccba_pkg::CNT_W-1:0]  r_cap, n_cap;
    logic [ccba_pkg::CNT_W-1:0]  r_best_len, n_best_len;
    logic                        r_full, n_full;
    logic                        r_pend_v, n_pend_v;
    logic [ccba_pkg::ID_W-1:0]   r_pend_id, n_pend_id;
    logic                        r_out_valid, n_out_valid;
    logic [ccba_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic [ccba_pkg::STAT_W-1:0] r_out_stat, n_out_stat;
    logic                        r_out_last, n_out_last;

    logic [PW-1:0]               w_n;
    logic [MAX_CORES-1:0]        w_exist;
    logic [IW-1:0]               w_idx;
    logic [MAX_CORES-1:0]        w_bit;
    logic                        w_seg;
    logic                        w_free;
    logic [ccba_pkg::CNT_W-1:0]  w_cnt_base;
    logic [MAX_CORES-1:0]        w_run_base;
    logic [ccba_pkg::CNT_W-1:0]  w_c;
    logic [MAX_CORES-1:0]        w_rm;
    logic                        w_end;
    logic                        w_done;
    logic                        w_out_free;
    logic [ccba_pkg::CNT_W-1:0]  w_shot_m1;

    // Cores that exist: core_count saturated to the bitmap size.
    always_comb begin
        w_n = (r_core_count > MAX_N) ? PW'(MAX_CORES) : PW'(r_core_count);
        for (int i = 0; i < MAX_CORES; i++) begin
            w_exist[i] = (PW'(i) < w_n);
        end
    end

    // Run tracking at the scan position; a segment start restarts the run.
    always_comb begin
        w_idx      = r_pos[IW-1:0];
        w_bit      = MAX_CORES'(1) << w_idx;
        w_seg      = (r_pos == '0) || r_seg_mask[w_idx];
        w_free     = r_map[w_idx];
        w_cnt_base = w_seg ? '0 : r_cnt;
        w_run_base = w_seg ? '0 : r_run;
        w_c        = w_cnt_base + ccba_pkg::CNT_W'(1);
        w_rm       = w_run_base | w_bit;
        w_end      = (r_pos >= w_n);
        w_out_free = !r_out_valid || i_out_ready;
        w_shot_m1  = r_shot - ccba_pkg::CNT_W'(1);
    end

    // End of the current scan.
    always_comb begin
        unique case (i_cmd.op)
            ccba_pkg::CMD_FIT:  w_done = w_end || (r_budget < r_shot);
            ccba_pkg::CMD_BEST: w_done = w_end || (r_best_len == r_cap);
            default:            w_done = w_end;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.in_load   = !i_op;
        o_status.in_zero   = (i_max_cores == '0);
        o_status.in_last   = i_last_one;
        o_status.scan_done = w_done;
        o_status.full      = r_full;
        o_status.shot_gt1  = (r_shot > ccba_pkg::CNT_W'(1));
        o_status.best_any  = (r_best_len != '0);
        o_status.out_free  = w_out_free;
    end

    // Per-cycle datapath step selected by the command.
    always_comb begin
        n_map       = r_map;
        n_snap      = r_snap;
        n_run       = r_run;
        n_best_mask = r_best_mask;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_fc        = r_fc;
        n_budget    = r_budget;
        n_shot      = r_shot;
        n_cap       = r_cap;
        n_best_len  = r_best_len;
        n_full      = r_full;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_id    = r_out_id;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;

        if (i_cmd.accept) begin
            if (!i_op) begin
                n_map = i_free_mask[MAX_CORES-1:0] & w_exist;
            end
            n_snap      = r_map;
            n_pos       = '0;
            n_cnt       = '0;
            n_run       = '0;
            n_fc        = '0;
            n_budget    = i_max_cores;
            n_shot      = (i_cores_per_shot == '0) ? ccba_pkg::CNT_W'(1) : i_cores_per_shot;
            n_full      = 1'b0;
            n_best_len  = '0;
            n_best_mask = '0;
            n_pend_v    = 1'b0;
        end

        unique case (i_cmd.op)
            ccba_pkg::CMD_NONE: begin
            end
            ccba_pkg::CMD_COUNT: begin
                if (w_done) begin
                    if (r_fc > r_budget) n_budget = r_fc;
                    n_pos = '0;
                end else begin
                    if (w_free) n_fc = r_fc + ccba_pkg::CNT_W'(1);
                    n_pos = r_pos + PW'(1);
                end
            end
            ccba_pkg::CMD_FIT: begin
                if (w_done) begin
                    n_pos = '0;
                    n_cnt = '0;
                    n_run = '0;
                    n_cap = (r_budget < w_shot_m1) ? r_budget : w_shot_m1;
                end else begin
                    n_pos = r_pos + PW'(1);
                    if (!w_free) begin
                        n_cnt = '0;
                        n_run = '0;
                    end else if (w_c == r_shot) begin
                        // A whole block is free: take it.
                        n_map    = r_map & ~w_rm;
                        n_budget = r_budget - r_shot;
                        n_full   = 1'b1;
                        n_cnt    = '0;
                        n_run    = '0;
                    end else begin
                        n_cnt = w_c;
                        n_run = w_rm;
                    end
                end
            end
            ccba_pkg::CMD_BEST: begin
                if (w_done) begin
                    n_map = r_map & ~r_best_mask;
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + PW'(1);
                    if (!w_free) begin
                        n_cnt = '0;
                        n_run = '0;
                    end else begin
                        n_cnt = w_c;
                        n_run = w_rm;
                        // First run that reaches a new width is the first fit for it.
                        if (w_c > r_best_len) begin
                            n_best_len  = w_c;
                            n_best_mask = w_rm;
                        end
                    end
                end
            end
            ccba_pkg::CMD_EMIT: begin
                if (!w_done) begin
                    if (r_snap[w_idx] && !r_map[w_idx]) begin
                        // One grant is held back so the final one can carry last.
                        if (!r_pend_v) begin
                            n_pend_v  = 1'b1;
                            n_pend_id = ccba_pkg::ID_W'(w_idx);
                            n_pos     = r_pos + PW'(1);
                        end else if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_id    = r_pend_id;
                            n_out_stat  = ccba_pkg::STAT_GRANT;
                            n_out_last  = 1'b0;
                            n_pend_id   = ccba_pkg::ID_W'(w_idx);
                            n_pos       = r_pos + PW'(1);
                        end
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            ccba_pkg::CMD_FINAL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_pend_id;
                    n_out_stat  = ccba_pkg::STAT_GRANT;
                    n_out_last  = 1'b1;
                    n_pend_v    = 1'b0;
                end
            end
            ccba_pkg::CMD_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_stat  = i_cmd.code;
                    n_out_last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mask   <= ccba_pkg::MASK_W'(1);
            r_core_count <= ccba_pkg::CNT_W'(64);
            r_map        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_v     <= 1'b0;
            r_full       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == ccba_pkg::CFG_SEG_MASK) r_seg_mask <= i_cfg_data;
                if (i_cfg_addr == ccba_pkg::CFG_CORE_COUNT) begin
                    r_core_count <= i_cfg_data[ccba_pkg::CNT_W-1:0];
                end
            end
            r_map       <= n_map;
            r_out_valid <= n_out_valid;
            r_pend_v    <= n_pend_v;
            r_full      <= n_full;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_snap      <= n_snap;
        r_run       <= n_run;
        r_best_mask <= n_best_mask;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_fc        <= n_fc;
        r_budget    <= n_budget;
        r_shot      <= n_shot;
        r_cap       <= n_cap;
        r_best_len  <= n_best_len;
        r_pend_id   <= n_pend_id;
        r_out_id    <= n_out_id;
        r_out_stat  <= n_out_stat;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_core_id   = r_out_id;
    assign o_stat      = r_out_stat;
    assign o_last      = r_out_last;

    // The bitmap gains free cores only through a load.
    a_map_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.accept && !i_op) |=> ((r_map & ~$past(r_map)) == '0))
        else $error("free bitmap gained cores outside a load");

    // The block pass never takes more than the budget.
    a_budget_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ccba_pkg::CMD_FIT) |=> (r_budget <= $past(r_budget)))
        else $error("budget wrapped in block pass");

    // The best-run search never exceeds its width limit.
    a_best_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ccba_pkg::CMD_BEST) |-> (r_best_len <= r_cap))
        else $error("best run wider than its limit");

    // A final grant is only sent with a grant held back.
    a_final_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ccba_pkg::CMD_FINAL) |-> r_pend_v)
        else $error("final grant without pending core");

endmodule

[src/contiguous_core_block_allocator_unit.sv]
// Sequence: a load or a zero-budget request goes straight to the response; an allocation
// scans the bitmap over the existing cores: an optional free-count scan, the block scan,
// the narrower-run scan when no block fits and blocks exceed one core, and the grant scan.
// Throughput: one item at a time; the next is taken once the last result is loaded.
// Reset (synchronous, active low) clears the bitmap to no free core, sets the segment mask to 1
// and the core count to 64, and empties the result register.
`timescale 1ns / 1ps

module contiguous_core_block_allocator_unit #(
    parameter int MAX_CORES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // free_mask[63:0], max_cores[70:64], cores_per_shot[77:71], zero fill
    input  logic [ccba_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // op
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // core_id[5:0], zero fill
    output logic [ccba_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [ccba_pkg::STAT_W-1:0]           m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [ccba_pkg::CFG_AW-1:0]           i_cfg_addr,
    input  logic [ccba_pkg::CFG_W-1:0]            i_cfg_data
);

    ccba_pkg::t_cmd            w_cmd;
    ccba_pkg::t_status         w_status;
    logic [ccba_pkg::ID_W-1:0] w_core_id;

    ccba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    ccba_dpath #(
        .MAX_CORES (MAX_CORES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_op             (s_axis_tuser),
        .i_free_mask      (s_axis_tdata[63:0]),
        .i_max_cores      (s_axis_tdata[70:64]),
        .i_cores_per_shot (s_axis_tdata[77:71]),
        .i_last_one       (s_axis_tlast),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_core_id        (w_core_id),
        .o_stat           (m_axis_tuser),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_core_id};

endmodule
